// File: hdl/rqec_pkg.sv
// ----------------------------------------------------------------------------
// rqec_pkg
// Types and codes shared by the quota entry cache.
// ----------------------------------------------------------------------------
package rqec_pkg;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SYNC    = 2'd2,
    OP_MARK    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_HIT        = 4'd0,
    ST_LOADED     = 4'd1,
    ST_QUOTA_OFF  = 4'd2,
    ST_TABLE_FULL = 4'd3,
    ST_READ_ERROR = 4'd4,
    ST_DIRTY      = 4'd5,
    ST_RELEASED   = 4'd6,
    ST_REL_UNREF  = 4'd7,
    ST_OVERFLOW   = 4'd8,
    ST_WRITTEN    = 4'd9,
    ST_CLEAN      = 4'd10,
    ST_MARKED     = 4'd11
  } status_e;

  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] user_id;
    logic [4:0]  mount_id;
    logic        quota_enabled;
    logic        fetch_failed;
    logic [5:0]  entry_index;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  result_entry;
    logic        fetch_request;
    logic        writeback_request;
    logic [15:0] disk_user;
    logic [4:0]  disk_mount;
  } out_t;

endpackage

// File: hdl/refcounted_quota_entry_cache.sv
// ----------------------------------------------------------------------------
// refcounted_quota_entry_cache
// Reference-counted quota entry cache with a least-recently-released free list.
//
// Each word in yields exactly one word out. A get with quota on walks the
// tag memory one entry per cycle until a match or the last entry; release,
// sync and mark need no walk. The tag, count and link memories each have
// one read port. Items are handled one at a time; a new word is taken as
// soon as the previous result sits in the output register. Reset takes
// effect at once through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_quota_entry_cache #(
  parameter int ENTRIES    = 64,
  parameter int MOUNT_BITS = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rqec_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rqec_pkg::out_t  out_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int MB = MOUNT_BITS;
  localparam int TW = 16 + MB;
  localparam logic [IW-1:0] Last = IW'(ENTRIES - 1);
  localparam logic [4:0] MountMask5 = 5'((1 << MOUNT_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SCAN, S_HIT, S_MISS, S_APP, S_REL, S_SYNC, S_DONE
  } state_e;

  state_e state_q, state_d;
  rqec_pkg::in_t  req_q, req_d;
  rqec_pkg::out_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [IW-1:0] h_q, h_d, chk_idx_q, chk_idx_d;
  logic [IW:0] scan_q, scan_d;
  logic chk_v_q, chk_v_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [IW:0] fcnt_q, fcnt_d;
  logic [ENTRIES-1:0] fnd_q, fnd_d, mod_q, mod_d;
  logic fnd_rd_q, mod_rd_q;
  logic [IW-1:0] mod_ra;

  // memories and their ports
  logic [TW-1:0] tag_mem [ENTRIES];
  logic [15:0]   cnt_mem [ENTRIES];
  logic [IW-1:0] nxt_mem [ENTRIES];
  logic [IW-1:0] prv_mem [ENTRIES];
  logic [ENTRIES-1:0] tag_vld_q, cnt_vld_q, nxt_vld_q, prv_vld_q;

  logic tag_we, cnt_we, nxt_we, prv_we;
  logic [IW-1:0] tag_wa, cnt_wa, nxt_wa, prv_wa;
  logic [IW-1:0] tag_ra, cnt_ra, nxt_ra, prv_ra;
  logic [TW-1:0] tag_wd, tag_rd_q, tag_eff;
  logic [15:0]   cnt_wd, cnt_rd_q, cnt_eff;
  logic [IW-1:0] nxt_wd, prv_wd, nxt_rd_q, prv_rd_q, nxt_eff, prv_eff;
  logic [IW-1:0] nxt_ra_q, prv_ra_q;
  logic tag_rv_q, cnt_rv_q, nxt_rv_q, prv_rv_q;

  logic [4:0]    mnt5;
  logic [MB-1:0] mnt;
  logic [IW-1:0] ix;
  logic          ix_out;
  logic          match;
  logic          do_rm, do_ap;
  logic [IW-1:0] rm_e, ap_e;

  assign mnt5   = req_q.mount_id & MountMask5;
  assign mnt    = MB'(mnt5);
  assign ix     = IW'(req_q.entry_index);
  assign ix_out = 32'(req_q.entry_index) >= ENTRIES;

  // unwritten entries read as their reset values
  assign tag_eff = tag_rv_q ? tag_rd_q : '0;
  assign cnt_eff = cnt_rv_q ? cnt_rd_q : '0;
  assign nxt_eff = nxt_rv_q ? nxt_rd_q :
                   (nxt_ra_q == '0 ? Last : IW'(nxt_ra_q - 1'b1));
  assign prv_eff = prv_rv_q ? prv_rd_q :
                   (prv_ra_q == Last ? '0 : IW'(prv_ra_q + 1'b1));

  assign match = chk_v_q && fnd_rd_q && (tag_eff == {req_q.user_id, mnt});

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // sequence one word through read, modify and write back
  always_comb begin
    state_d = state_q;
    req_d = req_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    h_d = h_q;
    scan_d = scan_q;
    chk_v_d = 1'b0;
    chk_idx_d = chk_idx_q;
    head_d = head_q;
    tail_d = tail_q;
    fcnt_d = fcnt_q;
    fnd_d = fnd_q;
    mod_d = mod_q;
    mod_ra = ix;
    tag_we = 1'b0; tag_wa = ix; tag_wd = {req_q.user_id, mnt}; tag_ra = ix;
    cnt_we = 1'b0; cnt_wa = ix; cnt_wd = '0; cnt_ra = ix;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = ix;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_ra = ix;
    do_rm = 1'b0; rm_e = h_q;
    do_ap = 1'b0; ap_e = ix;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        res_d = '0;
        res_d.result_entry = req_q.entry_index;
        state_d = S_DONE;
        if (req_q.opcode == rqec_pkg::OP_GET) begin
          res_d.result_entry = '0;
          if (!req_q.quota_enabled) begin
            res_d.status = rqec_pkg::ST_QUOTA_OFF;
          end else begin
            scan_d = '0;
            state_d = S_SCAN;
          end
        end else if (ix_out) begin
          case (req_q.opcode)
            rqec_pkg::OP_RELEASE: res_d.status = rqec_pkg::ST_REL_UNREF;
            rqec_pkg::OP_SYNC:    res_d.status = rqec_pkg::ST_CLEAN;
            default:              res_d.status = rqec_pkg::ST_MARKED;
          endcase
        end else begin
          case (req_q.opcode)
            rqec_pkg::OP_RELEASE: state_d = S_REL;
            rqec_pkg::OP_SYNC:    state_d = S_SYNC;
            default: begin
              mod_d[ix] = 1'b1;
              res_d.status = rqec_pkg::ST_MARKED;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue one tag read a cycle, compare the one read last cycle
        tag_ra = IW'(scan_q);
        cnt_ra = chk_idx_q;
        nxt_ra = match ? chk_idx_q : head_q;
        prv_ra = nxt_ra;
        mod_ra = head_q;
        if (scan_q < (IW+1)'(ENTRIES)) begin
          scan_d = scan_q + 1'b1;
          chk_v_d = 1'b1;
          chk_idx_d = IW'(scan_q);
        end
        if (match) begin
          h_d = chk_idx_q;
          state_d = S_HIT;
        end else if (chk_v_q && chk_idx_q == Last) begin
          state_d = S_MISS;
        end
      end
      S_HIT: begin
        res_d.result_entry = 6'(h_q);
        state_d = S_DONE;
        if (cnt_eff == rqec_pkg::CountMax) begin
          res_d.status = rqec_pkg::ST_OVERFLOW;
        end else begin
          res_d.status = rqec_pkg::ST_HIT;
          do_rm = (cnt_eff == '0);
          rm_e = h_q;
          cnt_we = 1'b1;
          cnt_wa = h_q;
          cnt_wd = cnt_eff + 16'd1;
        end
      end
      S_MISS: begin
        state_d = S_DONE;
        if (fcnt_q == '0) begin
          res_d.status = rqec_pkg::ST_TABLE_FULL;
        end else if (mod_rd_q) begin
          res_d.status = rqec_pkg::ST_DIRTY;
          res_d.result_entry = 6'(head_q);
        end else begin
          res_d.result_entry = 6'(head_q);
          res_d.fetch_request = 1'b1;
          res_d.disk_user = req_q.user_id;
          res_d.disk_mount = mnt5;
          do_rm = 1'b1;
          rm_e = head_q;
          tag_we = 1'b1;
          tag_wa = head_q;
          cnt_we = 1'b1;
          cnt_wa = head_q;
          cnt_wd = req_q.fetch_failed ? 16'd0 : 16'd1;
          fnd_d[head_q] = !req_q.fetch_failed;
          mod_d[head_q] = 1'b0;
          if (req_q.fetch_failed) begin
            res_d.status = rqec_pkg::ST_READ_ERROR;
            h_d = head_q;
            state_d = S_APP;
          end else begin
            res_d.status = rqec_pkg::ST_LOADED;
          end
        end
      end
      S_APP: begin
        do_ap = 1'b1;
        ap_e = h_q;
        state_d = S_DONE;
      end
      S_REL: begin
        state_d = S_DONE;
        if (cnt_eff == '0) begin
          res_d.status = rqec_pkg::ST_REL_UNREF;
        end else if (cnt_eff == 16'd1) begin
          if (mod_rd_q && !req_q.quota_enabled) begin
            res_d.status = rqec_pkg::ST_QUOTA_OFF;
          end else begin
            res_d.status = rqec_pkg::ST_RELEASED;
            if (mod_rd_q) begin
              mod_d[ix] = 1'b0;
              res_d.writeback_request = 1'b1;
              res_d.disk_user = tag_eff[TW-1:MB];
              res_d.disk_mount = 5'(tag_eff[MB-1:0]);
              res_d.status = rqec_pkg::ST_WRITTEN;
            end
            do_ap = 1'b1;
            ap_e = ix;
            cnt_we = 1'b1;
            cnt_wd = '0;
          end
        end else begin
          cnt_we = 1'b1;
          cnt_wd = cnt_eff - 16'd1;
          res_d.status = rqec_pkg::ST_RELEASED;
        end
      end
      S_SYNC: begin
        state_d = S_DONE;
        if (!mod_rd_q) begin
          res_d.status = rqec_pkg::ST_CLEAN;
        end else if (!req_q.quota_enabled) begin
          res_d.status = rqec_pkg::ST_QUOTA_OFF;
        end else begin
          mod_d[ix] = 1'b0;
          res_d.writeback_request = 1'b1;
          res_d.disk_user = tag_eff[TW-1:MB];
          res_d.disk_mount = 5'(tag_eff[MB-1:0]);
          res_d.status = rqec_pkg::ST_WRITTEN;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // unlink an entry from the free list
    if (do_rm && fcnt_q != '0) begin
      if (rm_e == head_q) begin
        head_d = nxt_eff;
      end else begin
        nxt_we = 1'b1; nxt_wa = prv_eff; nxt_wd = nxt_eff;
      end
      if (rm_e == tail_q) begin
        tail_d = prv_eff;
      end else begin
        prv_we = 1'b1; prv_wa = nxt_eff; prv_wd = prv_eff;
      end
      fcnt_d = fcnt_q - 1'b1;
    end

    // append an entry at the free list tail
    if (do_ap) begin
      if (fcnt_q == '0) begin
        head_d = ap_e;
      end else begin
        nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = ap_e;
        prv_we = 1'b1; prv_wa = ap_e; prv_wd = tail_q;
      end
      tail_d = ap_e;
      fcnt_d = fcnt_q + 1'b1;
    end
  end

  // hold state, free list and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      chk_v_q <= 1'b0;
      scan_q <= '0;
      head_q <= Last;
      tail_q <= '0;
      fcnt_q <= (IW+1)'(ENTRIES);
      fnd_q <= '0;
      mod_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      chk_v_q <= chk_v_d;
      scan_q <= scan_d;
      head_q <= head_d;
      tail_q <= tail_d;
      fcnt_q <= fcnt_d;
      fnd_q <= fnd_d;
      mod_q <= mod_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
    h_q <= h_d;
    chk_idx_q <= chk_idx_d;
  end

  // memory arrays with registered reads
  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    tag_rd_q <= tag_mem[tag_ra];
    cnt_rd_q <= cnt_mem[cnt_ra];
    nxt_rd_q <= nxt_mem[nxt_ra];
    prv_rd_q <= prv_mem[prv_ra];
    nxt_ra_q <= nxt_ra;
    prv_ra_q <= prv_ra;
    fnd_rd_q <= fnd_q[tag_ra];
    mod_rd_q <= mod_q[mod_ra];
  end

  // track which entries were written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= '0;
      cnt_vld_q <= '0;
      nxt_vld_q <= '0;
      prv_vld_q <= '0;
      tag_rv_q <= 1'b0;
      cnt_rv_q <= 1'b0;
      nxt_rv_q <= 1'b0;
      prv_rv_q <= 1'b0;
    end else begin
      if (tag_we) tag_vld_q[tag_wa] <= 1'b1;
      if (cnt_we) cnt_vld_q[cnt_wa] <= 1'b1;
      if (nxt_we) nxt_vld_q[nxt_wa] <= 1'b1;
      if (prv_we) prv_vld_q[prv_wa] <= 1'b1;
      tag_rv_q <= tag_vld_q[tag_ra];
      cnt_rv_q <= cnt_vld_q[cnt_ra];
      nxt_rv_q <= nxt_vld_q[nxt_ra];
      prv_rv_q <= prv_vld_q[prv_ra];
    end
  end

  // free count never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= (IW+1)'(ENTRIES))
    else $error("free count exceeds table size");

  // a fetch comes only with a load or a read error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.fetch_request |->
      (out_o.status == rqec_pkg::ST_LOADED || out_o.status == rqec_pkg::ST_READ_ERROR))
    else $error("fetch request with wrong status");

  // a writeback comes only with the written back status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.writeback_request |-> out_o.status == rqec_pkg::ST_WRITTEN)
    else $error("writeback request with wrong status");

  // an accepted word goes to dispatch next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DISP)
    else $error("accepted word not dispatched");

endmodule

// File: test/tb_refcounted_quota_entry_cache.sv
// ----------------------------------------------------------------------------
// tb_refcounted_quota_entry_cache
// Self-checking bench for the quota entry cache: every accepted request word
// runs through a bit-exact predictor, and each result word is compared field
// by field with the oldest prediction. Directed corner cases come first, then
// random traffic built around entries actually held, a fill to a full table,
// and random backpressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class quota_cache_scoreboard;
  localparam int NumEntries = 64;

  logic [15:0] user_tag_q  [NumEntries];
  logic [4:0]  mount_tag_q [NumEntries];
  bit          findable_q  [NumEntries];
  logic [15:0] refs_q      [NumEntries];
  bit          dirty_q     [NumEntries];
  logic [5:0]  link_next_q [NumEntries];
  logic [5:0]  link_prev_q [NumEntries];
  logic [5:0]  free_head_q;
  logic [5:0]  free_tail_q;
  int unsigned free_cnt_q;

  rqec_pkg::out_t expected_q [$];
  int          held_q [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned status_seen [16];

  function new();
    for (int i = 0; i < NumEntries; i++) begin
      user_tag_q[i]  = '0;
      mount_tag_q[i] = '0;
      findable_q[i]  = 0;
      refs_q[i]      = '0;
      dirty_q[i]     = 0;
      link_next_q[i] = 6'((i + NumEntries - 1) % NumEntries);
      link_prev_q[i] = 6'((i + 1) % NumEntries);
    end
    for (int i = 0; i < 16; i++) status_seen[i] = 0;
    free_head_q = 6'(NumEntries - 1);
    free_tail_q = '0;
    free_cnt_q  = NumEntries;
    errors      = 0;
    checked     = 0;
  endfunction

  // Drop an entry out of the free list
  function void unlink(int e);
    int p;
    int n;
    p = link_prev_q[e];
    n = link_next_q[e];
    if (free_cnt_q == 0) return;
    if (e == free_head_q) free_head_q = 6'(n);
    else link_next_q[p] = 6'(n);
    if (e == free_tail_q) free_tail_q = 6'(p);
    else link_prev_q[n] = 6'(p);
    free_cnt_q--;
  endfunction

  // Append an entry at the free-list tail
  function void append(int e);
    if (free_cnt_q == 0) begin
      free_head_q = 6'(e);
    end else begin
      link_next_q[free_tail_q] = 6'(e);
      link_prev_q[e] = free_tail_q;
    end
    free_tail_q = 6'(e);
    free_cnt_q++;
  endfunction

  // Predict the result of one accepted request word
  function void note_input(rqec_pkg::in_t w);
    rqec_pkg::out_t r;
    int   hit;
    int   h;
    int   idx;
    r   = '0;
    hit = -1;
    idx = w.entry_index;
    if (w.opcode == rqec_pkg::OP_GET) begin
      if (!w.quota_enabled) begin
        r.status = rqec_pkg::ST_QUOTA_OFF;
      end else begin
        for (int i = 0; i < NumEntries; i++) begin
          if (hit < 0 && findable_q[i] && user_tag_q[i] == w.user_id &&
              mount_tag_q[i] == w.mount_id) hit = i;
        end
        if (hit >= 0) begin
          r.result_entry = 6'(hit);
          if (refs_q[hit] == rqec_pkg::CountMax) begin
            r.status = rqec_pkg::ST_OVERFLOW;
          end else begin
            if (refs_q[hit] == 0) unlink(hit);
            refs_q[hit]++;
            r.status = rqec_pkg::ST_HIT;
            held_q.push_back(hit);
          end
        end else if (free_cnt_q == 0) begin
          r.status = rqec_pkg::ST_TABLE_FULL;
        end else begin
          h = free_head_q;
          r.result_entry = 6'(h);
          if (dirty_q[h]) begin
            r.status = rqec_pkg::ST_DIRTY;
          end else begin
            unlink(h);
            dirty_q[h]       = 0;
            user_tag_q[h]    = w.user_id;
            mount_tag_q[h]   = w.mount_id;
            r.fetch_request  = 1'b1;
            r.disk_user      = w.user_id;
            r.disk_mount     = w.mount_id;
            if (w.fetch_failed) begin
              findable_q[h] = 0;
              append(h);
              refs_q[h] = '0;
              r.status  = rqec_pkg::ST_READ_ERROR;
            end else begin
              findable_q[h] = 1;
              refs_q[h]     = 16'd1;
              r.status      = rqec_pkg::ST_LOADED;
              held_q.push_back(h);
            end
          end
        end
      end
    end else begin
      r.result_entry = 6'(idx);
      if (w.opcode == rqec_pkg::OP_RELEASE) begin
        if (refs_q[idx] == 0) begin
          r.status = rqec_pkg::ST_REL_UNREF;
        end else if (refs_q[idx] == 1) begin
          if (dirty_q[idx] && !w.quota_enabled) begin
            r.status = rqec_pkg::ST_QUOTA_OFF;
          end else begin
            r.status = rqec_pkg::ST_RELEASED;
            if (dirty_q[idx]) begin
              dirty_q[idx]        = 0;
              r.writeback_request = 1'b1;
              r.disk_user         = user_tag_q[idx];
              r.disk_mount        = mount_tag_q[idx];
              r.status            = rqec_pkg::ST_WRITTEN;
            end
            append(idx);
            refs_q[idx] = '0;
          end
        end else begin
          refs_q[idx]--;
          r.status = rqec_pkg::ST_RELEASED;
        end
      end else if (w.opcode == rqec_pkg::OP_SYNC) begin
        if (!dirty_q[idx]) begin
          r.status = rqec_pkg::ST_CLEAN;
        end else if (!w.quota_enabled) begin
          r.status = rqec_pkg::ST_QUOTA_OFF;
        end else begin
          dirty_q[idx]        = 0;
          r.writeback_request = 1'b1;
          r.disk_user         = user_tag_q[idx];
          r.disk_mount        = mount_tag_q[idx];
          r.status            = rqec_pkg::ST_WRITTEN;
        end
      end else begin
        dirty_q[idx] = 1;
        r.status     = rqec_pkg::ST_MARKED;
      end
    end
    expected_q.push_back(r);
  endfunction

  task report(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Compare one result word with the oldest prediction
  task check_result(rqec_pkg::out_t got);
    rqec_pkg::out_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result word", 1, 0);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    status_seen[want.status]++;
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.result_entry != want.result_entry)
      report("result_entry", got.result_entry, want.result_entry);
    if (got.fetch_request != want.fetch_request)
      report("fetch_request", got.fetch_request, want.fetch_request);
    if (got.writeback_request != want.writeback_request)
      report("writeback_request", got.writeback_request, want.writeback_request);
    if (got.disk_user != want.disk_user) report("disk_user", got.disk_user, want.disk_user);
    if (got.disk_mount != want.disk_mount)
      report("disk_mount", got.disk_mount, want.disk_mount);
  endtask
endclass

module tb_refcounted_quota_entry_cache;
  localparam int WatchdogLimit = 5000;
  localparam int LongHold      = 400;
  localparam int InBits        = $bits(rqec_pkg::in_t);

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rqec_pkg::in_t  in_word;
  logic out_valid;
  logic out_ready;
  rqec_pkg::out_t out_word;

  quota_cache_scoreboard sb;
  bit quiet;
  bit long_hold;
  int unsigned stall_cycles;
  int unsigned sent;

  refcounted_quota_entry_cache u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_word)
  );

  always #5 clk = ~clk;

  function automatic rqec_pkg::in_t mk(rqec_pkg::op_e op, logic [15:0] user,
                                       logic [4:0] mount, bit qon, bit ffail,
                                       logic [5:0] idx);
    rqec_pkg::in_t w;
    w.opcode        = op;
    w.user_id       = user;
    w.mount_id      = mount;
    w.quota_enabled = qon;
    w.fetch_failed  = ffail;
    w.entry_index   = idx;
    return w;
  endfunction

  // Offer one word, with an optional idle burst ahead of it
  task automatic send(rqec_pkg::in_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    sent++;
    @(negedge clk);
  endtask

  // Hold valid low until every prediction has been matched
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_random();
    rqec_pkg::in_t w;
    int  pick;
    int  k;
    w = rqec_pkg::in_t'(InBits'({$urandom, $urandom}));
    w.quota_enabled = ($urandom_range(0, 9) != 0);
    w.fetch_failed  = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 9) < 7) w.user_id = 16'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 7) w.mount_id = 5'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.opcode = rqec_pkg::OP_GET;
    end else if (pick < 72) begin
      w.opcode = rqec_pkg::OP_RELEASE;
      if (sb.held_q.size() != 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, sb.held_q.size() - 1);
        w.entry_index = 6'(sb.held_q[k]);
        sb.held_q.delete(k);
      end
    end else if (pick < 86) begin
      w.opcode = rqec_pkg::OP_MARK;
      if (sb.held_q.size() != 0 && $urandom_range(0, 1) != 0)
        w.entry_index = 6'(sb.held_q[$urandom_range(0, sb.held_q.size() - 1)]);
    end else begin
      w.opcode = rqec_pkg::OP_SYNC;
      if (sb.held_q.size() != 0 && $urandom_range(0, 1) != 0)
        w.entry_index = 6'(sb.held_q[$urandom_range(0, sb.held_q.size() - 1)]);
    end
    send(w);
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check result words and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_word);
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("refcounted_quota_entry_cache regression: fail");
        $finish;
      end
    end
  end

  initial begin
    sb           = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    quiet        = 0;
    long_hold    = 0;
    stall_cycles = 0;
    sent         = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed corners
    send(mk(rqec_pkg::OP_GET, 16'h1234, 5'd3, 0, 0, 6'd0));     // quota off on get
    send(mk(rqec_pkg::OP_GET, 16'hFFFF, 5'd31, 1, 0, 6'd0));    // miss, load entry 63
    send(mk(rqec_pkg::OP_GET, 16'hFFFF, 5'd31, 1, 0, 6'd0));    // hit, count 2
    send(mk(rqec_pkg::OP_RELEASE, 16'h0, 5'd0, 1, 0, 6'd63));   // count back to 1
    send(mk(rqec_pkg::OP_MARK, 16'h0, 5'd0, 1, 0, 6'd63));
    send(mk(rqec_pkg::OP_RELEASE, 16'h0, 5'd0, 0, 0, 6'd63));   // writeback needed, quota off
    send(mk(rqec_pkg::OP_SYNC, 16'h0, 5'd0, 0, 0, 6'd63));      // sync with quota off
    send(mk(rqec_pkg::OP_SYNC, 16'h0, 5'd0, 1, 0, 6'd63));      // written back
    send(mk(rqec_pkg::OP_SYNC, 16'h0, 5'd0, 1, 0, 6'd63));      // clean
    send(mk(rqec_pkg::OP_MARK, 16'h0, 5'd0, 1, 0, 6'd63));
    send(mk(rqec_pkg::OP_RELEASE, 16'h0, 5'd0, 1, 0, 6'd63));   // last release writes back
    send(mk(rqec_pkg::OP_RELEASE, 16'h0, 5'd0, 1, 0, 6'd63));   // release of unreferenced
    send(mk(rqec_pkg::OP_GET, 16'h0000, 5'd0, 1, 1, 6'd0));     // read error on miss
    send(mk(rqec_pkg::OP_MARK, 16'h0, 5'd0, 1, 0, 6'd61));      // dirty the free-list head
    send(mk(rqec_pkg::OP_GET, 16'h0005, 5'd1, 1, 0, 6'd0));     // dirty victim
    send(mk(rqec_pkg::OP_SYNC, 16'h0, 5'd0, 1, 0, 6'd61));
    send(mk(rqec_pkg::OP_GET, 16'h0005, 5'd1, 1, 0, 6'd0));     // loaded into entry 61
    send(mk(rqec_pkg::OP_GET, 16'hFFFF, 5'd31, 1, 0, 6'd0));    // hit on a free-list entry
    send(mk(rqec_pkg::OP_MARK, 16'h0, 5'd0, 1, 0, 6'd0));
    send(mk(rqec_pkg::OP_SYNC, 16'h0, 5'd0, 1, 0, 6'd0));
    send(mk(rqec_pkg::OP_RELEASE, 16'h0, 5'd0, 1, 0, 6'd61));
    send(mk(rqec_pkg::OP_RELEASE, 16'h0, 5'd0, 1, 0, 6'd63));
    sb.held_q.delete();

    // Pause the sender until everything is back, then fill up under a long stall
    drain();
    long_hold = 1;
    repeat (700) send_random();

    // Clean every entry, then fill the table until it reports full
    drain();
    for (int i = 0; i < 64; i++) send(mk(rqec_pkg::OP_SYNC, 16'h0, 5'd0, 1, 0, 6'(i)));
    for (int i = 0; i < 70; i++)
      send(mk(rqec_pkg::OP_GET, 16'(16'h8000 + i), 5'(i), 1, 0, 6'd0));
    while (sb.held_q.size() != 0)
      send(mk(rqec_pkg::OP_RELEASE, 16'h0, 5'd0, 1, 0, 6'(sb.held_q.pop_front())));

    repeat (450) send_random();
    quiet = 1;
    repeat (300) send_random();
    in_valid <= 1'b0;

    // Wait out the tail
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.expected_q.size() != 0) sb.report("results left over", sb.expected_q.size(), 0);

    $display("covered %0d request words and %0d result words", sent, sb.checked);
    $display("hits %0d, loads %0d, read errors %0d, dirty victims %0d, full %0d, writebacks %0d",
             sb.status_seen[rqec_pkg::ST_HIT], sb.status_seen[rqec_pkg::ST_LOADED],
             sb.status_seen[rqec_pkg::ST_READ_ERROR], sb.status_seen[rqec_pkg::ST_DIRTY],
             sb.status_seen[rqec_pkg::ST_TABLE_FULL], sb.status_seen[rqec_pkg::ST_WRITTEN]);
    if (sb.errors == 0) begin
      $display("refcounted_quota_entry_cache regression: pass");
    end else begin
      $display("refcounted_quota_entry_cache regression: fail");
    end
    $finish;
  end
endmodule
